// ----- design/klm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klm_pkg
// command and status codes and the controller/datapath interface types
// ----------------------------------------------------------------------------
package klm_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_IRESET = 3'd3;
    localparam logic [2:0] CMD_ISTEP  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;

    // datapath operations requested by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;  // take beat, start walk at head
    localparam logic [3:0] OP_READ      = 4'd2;  // issue store read at walk pointer
    localparam logic [3:0] OP_ADVANCE   = 4'd3;  // compare done, record match or move to next link
    localparam logic [3:0] OP_UPDATE    = 4'd4;  // overwrite value of matched slot
    localparam logic [3:0] OP_POP       = 4'd5;  // pop the free stack (decrement its top)
    localparam logic [3:0] OP_LINK      = 4'd6;  // write new entry at head
    localparam logic [3:0] OP_UNLINK    = 4'd7;  // unlink matched slot
    localparam logic [3:0] OP_CUR_READ  = 4'd8;  // read entry under cursor
    localparam logic [3:0] OP_CUR_MOVE  = 4'd9;  // cursor to head or successor
    localparam logic [3:0] OP_CUR_DONE  = 4'd10; // result from cursor entry
    localparam logic [3:0] OP_FINISH    = 4'd11; // load result with given status
    localparam logic [3:0] OP_FOUND     = 4'd12; // lookup hit result

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] status;
    } klm_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       walk_null;   // walk pointer is null or bound reached
        logic       key_match;   // read data key equals beat key
        logic       full;        // free stack empty or still being filled
        logic       cur_null;    // cursor is null
        logic       filling;     // free stack sweep after reset in progress
    } klm_stat_t;

endpackage
`default_nettype wire

// ----- design/klm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module klm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/klm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klm_datapath
// entry stores, free stack, list pointers, walk and result registers
// ----------------------------------------------------------------------------
module klm_datapath
    import klm_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [2:0]                 command,
    input  wire logic signed [31:0]         key,
    input  wire logic [31:0]                value,
    input  wire klm_cmd_t                   cmd,
    output klm_stat_t                       stat,
    output logic [2:0]                      status,
    output logic signed [31:0]              key_out,
    output logic [31:0]                     value_out,
    output logic [$clog2(CAPACITY+1)-1:0]   entry_total,
    output logic                            at_end
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NULL = PW'(CAPACITY);

    logic [2:0]    cmd_reg;
    logic [31:0]   key_reg, value_reg;
    logic [PW-1:0] walk_reg, prev_reg, match_reg, match_prev_reg;
    logic [PW-1:0] steps_reg;
    logic [PW-1:0] head_reg, cursor_reg, count_reg, free_top_reg;
    logic [AW:0]   init_reg;   // free stack fill sweep

    // ram ports
    logic          kv_we, lk_we, fs_we;
    logic [AW-1:0] kv_waddr, lk_waddr, fs_waddr, rd_addr, fs_raddr;
    logic [31:0]   k_rd, v_rd, v_wdata;
    logic [PW-1:0] lk_rd, lk_wdata;
    logic [AW-1:0] fs_rd, fs_wdata;
    logic [AW-1:0] walk_a, match_a;

    assign walk_a  = walk_reg[AW-1:0];
    assign match_a = match_reg[AW-1:0];

    klm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(kv_we && (cmd.op == OP_LINK)), .waddr(kv_waddr),
        .wdata(key_reg), .raddr(rd_addr), .rdata(k_rd));
    klm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(kv_we), .waddr(kv_waddr),
        .wdata(v_wdata), .raddr(rd_addr), .rdata(v_rd));
    klm_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr),
        .wdata(lk_wdata), .raddr(rd_addr), .rdata(lk_rd));
    klm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
        .clk(clk), .we(fs_we), .waddr(fs_waddr),
        .wdata(fs_wdata), .raddr(fs_raddr), .rdata(fs_rd));

    logic init_busy;
    assign init_busy = (init_reg != (AW+1)'(CAPACITY));

    always_comb
    begin
        kv_we    = 1'b0;
        kv_waddr = match_a;
        v_wdata  = value_reg;
        lk_we    = 1'b0;
        lk_waddr = match_prev_reg[AW-1:0];
        lk_wdata = lk_rd;
        fs_we    = 1'b0;
        fs_waddr = free_top_reg[AW-1:0];
        fs_wdata = match_a;
        fs_raddr = AW'(free_top_reg - PW'(1));
        rd_addr  = walk_a;
        if (init_busy)
        begin
            fs_we    = 1'b1;
            fs_waddr = init_reg[AW-1:0];
            fs_wdata = AW'(CAPACITY - 1) - init_reg[AW-1:0];
        end
        case (cmd.op)
            OP_UPDATE:
            begin
                kv_we = 1'b1;
            end
            OP_LINK:
            begin
                kv_we    = 1'b1;
                kv_waddr = fs_rd;
                lk_we    = 1'b1;
                lk_waddr = fs_rd;
                lk_wdata = head_reg;
            end
            OP_UNLINK:
            begin
                lk_we = (match_prev_reg != NULL);
                fs_we = (free_top_reg < NULL);
            end
            OP_CUR_READ, OP_CUR_MOVE:
            begin
                rd_addr = cursor_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign stat.command   = cmd_reg;
    assign stat.walk_null = (walk_reg >= NULL) || (steps_reg == NULL);
    assign stat.key_match = (k_rd == key_reg);
    assign stat.full      = (free_top_reg == '0) || init_busy;
    assign stat.cur_null  = (cursor_reg >= NULL);
    assign stat.filling   = init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= '0;
            head_reg     <= NULL;
            cursor_reg   <= NULL;
            count_reg    <= '0;
            free_top_reg <= NULL;
            status       <= ST_OK;
            key_out      <= '0;
            value_out    <= '0;
        end
        else
        begin
            if (init_busy)
            begin
                init_reg <= init_reg + (AW+1)'(1);
            end
            case (cmd.op)
                OP_LATCH:
                begin
                    cmd_reg        <= command;
                    key_reg        <= key;
                    value_reg      <= value;
                    walk_reg       <= head_reg;
                    prev_reg       <= NULL;
                    steps_reg      <= '0;
                    match_reg      <= NULL;
                    match_prev_reg <= NULL;
                end
                OP_ADVANCE:
                begin
                    if (stat.key_match)
                    begin
                        match_reg      <= walk_reg;
                        match_prev_reg <= prev_reg;
                    end
                    else
                    begin
                        prev_reg  <= walk_reg;
                        walk_reg  <= lk_rd;
                        steps_reg <= steps_reg + PW'(1);
                    end
                end
                OP_POP:
                begin
                    free_top_reg <= free_top_reg - PW'(1);
                end
                OP_LINK:
                begin
                    head_reg  <= PW'(fs_rd);
                    count_reg <= count_reg + PW'(1);
                end
                OP_UNLINK:
                begin
                    // lk_rd holds the successor of the matched slot
                    if (match_prev_reg == NULL)
                    begin
                        head_reg <= lk_rd;
                    end
                    if (cursor_reg == match_reg)
                    begin
                        cursor_reg <= (lk_rd >= NULL) ? NULL : lk_rd;
                    end
                    if (free_top_reg < NULL)
                    begin
                        free_top_reg <= free_top_reg + PW'(1);
                    end
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - PW'(1);
                    end
                end
                OP_CUR_MOVE:
                begin
                    if (cmd_reg == CMD_IRESET)
                    begin
                        cursor_reg <= head_reg;
                    end
                    else if (cursor_reg < NULL)
                    begin
                        cursor_reg <= (lk_rd >= NULL) ? NULL : lk_rd;
                    end
                end
                OP_CUR_DONE:
                begin
                    status    <= cmd.status;
                    key_out   <= cursor_reg < NULL ? k_rd : '0;
                    value_out <= cursor_reg < NULL ? v_rd : '0;
                end
                OP_FOUND:
                begin
                    status    <= ST_OK;
                    key_out   <= '0;
                    value_out <= v_rd;
                end
                OP_FINISH:
                begin
                    status    <= cmd.status;
                    key_out   <= '0;
                    value_out <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign entry_total = count_reg;
    assign at_end      = (cursor_reg >= NULL);

    count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL)
        else $error("entry count beyond capacity");
    free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= NULL)
        else $error("free stack top beyond capacity");
    link_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LINK |=> count_reg == $past(count_reg) + PW'(1))
        else $error("link did not grow the count");

endmodule
`default_nettype wire

// ----- design/klm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klm_ctrl
// command sequencer: beat capture, list walk, edit and result handshake
// ----------------------------------------------------------------------------
module klm_ctrl
    import klm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire klm_stat_t stat,
    output klm_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_HIT    = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_UNLINK = 4'd7;
    localparam logic [3:0] S_CRD    = 4'd8;
    localparam logic [3:0] S_CMOV   = 4'd9;
    localparam logic [3:0] S_CRD2   = 4'd10;
    localparam logic [3:0] S_CWAIT  = 4'd11;
    localparam logic [3:0] S_CDONE  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_POPW   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic busy;
    assign busy     = (state_reg != S_IDLE);
    // a new beat enters only once the last result is taken and the sweep is over
    assign in_ready = !busy && !stat.filling && !(out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.status     = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.command)
                    CMD_INSERT, CMD_LOOKUP, CMD_REMOVE: state_next = S_RD;
                    CMD_IRESET, CMD_ISTEP:              state_next = S_CRD;
                    default:
                    begin
                        cmd.op     = OP_FINISH;
                        cmd.status = ST_OK;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RD:
            begin
                if (stat.walk_null)
                begin
                    if (stat.command == CMD_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.op     = OP_FINISH;
                            cmd.status = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_POPW;
                        end
                    end
                    else
                    begin
                        cmd.op     = OP_FINISH;
                        cmd.status = ST_MISSING;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.op     = OP_READ;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.op     = OP_ADVANCE;
                state_next = stat.key_match ? S_HIT : S_RD;
            end
            S_HIT:
            begin
                // read data still holds the matched entry
                case (stat.command)
                    CMD_INSERT:
                    begin
                        cmd.op     = OP_UPDATE;
                        state_next = S_LINK;
                    end
                    CMD_LOOKUP:
                    begin
                        cmd.op     = OP_FOUND;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        cmd.op     = OP_UNLINK;
                        state_next = S_UNLINK;
                    end
                endcase
            end
            S_LINK:
            begin
                cmd.op     = OP_FINISH;
                cmd.status = ST_UPDATED;
                state_next = S_OUT;
            end
            S_POPW:
            begin
                // free stack read issued at top minus one
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.op     = OP_LINK;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                cmd.op     = (stat.command == CMD_INSERT) ? OP_POP : OP_NONE;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                cmd.op     = OP_FINISH;
                cmd.status = ST_OK;
                state_next = S_OUT;
            end
            S_CRD:
            begin
                cmd.op     = OP_CUR_READ;
                state_next = S_CMOV;
            end
            S_CMOV:
            begin
                cmd.op     = OP_CUR_MOVE;
                state_next = S_CRD2;
            end
            S_CRD2:
            begin
                cmd.op     = OP_CUR_READ;
                state_next = S_CDONE;
            end
            S_CDONE:
            begin
                cmd.op     = OP_CUR_DONE;
                cmd.status = stat.cur_null ? ST_END : ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DISP)
        else $error("accepted beat did not start a command");
    no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("ready while a command is in progress");
    result_raise: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid_reg)
        else $error("finished command raised no result");

endmodule
`default_nettype wire

// ----- design/keyed_list_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// insert, lookup and remove walk the list from the head, entry by entry, up to
// CAPACITY entries; iterator commands do not walk the list
// throughput: one command at a time; the controller takes no new beat while busy
// reset: map empty, iterator at end; the free stack is filled by a sweep
// after reset, during which no beat is taken
// ----------------------------------------------------------------------------
// keyed_list_map
// bounded key/value map kept as a linked list in on-chip stores
// ----------------------------------------------------------------------------
module keyed_list_map
    import klm_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               command,
    input  wire logic signed [31:0]       key,
    input  wire logic [31:0]              value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [2:0]                    status,
    output logic signed [31:0]            key_out,
    output logic [31:0]                   value_out,
    output logic [$clog2(CAPACITY+1)-1:0] entry_total,
    output logic                          at_end
);

    klm_cmd_t  cmd;
    klm_stat_t stat;

    klm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd));

    klm_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .command(command), .key(key), .value(value),
        .cmd(cmd), .stat(stat), .status(status), .key_out(key_out),
        .value_out(value_out), .entry_total(entry_total), .at_end(at_end));

endmodule
`default_nettype wire

// ----- bench/keyed_list_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_list_map_tb
// self-checking bench for the linked-list key/value map: commands are fed
// through the input handshake under varying idle patterns, a software copy of
// the list predicts every result, and results are compared in order
// ----------------------------------------------------------------------------
module keyed_list_map_tb;
    import klm_pkg::*;

    localparam int SLOTS = 64;
    localparam int NIL   = SLOTS;

    // software copy of the map, with its own free stack and iterator
    class map_scoreboard;
        logic [31:0] key_mem [SLOTS];
        logic [31:0] val_mem [SLOTS];
        int          next_mem [SLOTS];
        int          spare [SLOTS];
        int          spare_top;
        int          head;
        int          held;
        int          iter;
        logic [2:0]  exp_status [$];
        logic [31:0] exp_key [$];
        logic [31:0] exp_val [$];
        logic [6:0]  exp_total [$];
        logic        exp_end [$];
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                next_mem[i] = NIL;
                spare[i] = SLOTS - 1 - i;
            end
            spare_top = SLOTS;
            head = NIL;
            held = 0;
            iter = NIL;
            errors = 0;
        endfunction

        function int find(logic [31:0] k, output int prev);
            int at;
            int back;
            at = head;
            back = NIL;
            prev = NIL;
            for (int n = 0; n < SLOTS && at < SLOTS; n++)
            begin
                if (key_mem[at] == k)
                begin
                    prev = back;
                    return at;
                end
                back = at;
                at = next_mem[at];
            end
            return NIL;
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        // predict the result of an accepted command beat
        function void note_command(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
            logic [2:0]  st;
            logic [31:0] ko;
            logic [31:0] vo;
            int          slot;
            int          prev;
            int          nxt;
            st = ST_OK;
            ko = '0;
            vo = '0;
            case (cmd)
                CMD_INSERT:
                begin
                    slot = find(k, prev);
                    if (slot < SLOTS)
                    begin
                        val_mem[slot] = v;
                        st = ST_UPDATED;
                    end
                    else if (spare_top == 0)
                        st = ST_FULL;
                    else
                    begin
                        spare_top--;
                        slot = spare[spare_top];
                        key_mem[slot] = k;
                        val_mem[slot] = v;
                        next_mem[slot] = head;
                        head = slot;
                        held++;
                    end
                end
                CMD_LOOKUP:
                begin
                    slot = find(k, prev);
                    if (slot < SLOTS)
                        vo = val_mem[slot];
                    else
                        st = ST_MISSING;
                end
                CMD_REMOVE:
                begin
                    slot = find(k, prev);
                    if (slot < SLOTS)
                    begin
                        nxt = next_mem[slot];
                        if (prev < SLOTS)
                            next_mem[prev] = nxt;
                        else
                            head = nxt;
                        if (iter == slot)
                            iter = nxt;
                        spare[spare_top] = slot;
                        spare_top++;
                        held--;
                    end
                    else
                        st = ST_MISSING;
                end
                CMD_IRESET, CMD_ISTEP:
                begin
                    if (cmd == CMD_IRESET)
                        iter = head;
                    else if (iter < SLOTS)
                        iter = next_mem[iter];
                    if (iter < SLOTS)
                    begin
                        ko = key_mem[iter];
                        vo = val_mem[iter];
                    end
                    else
                    begin
                        iter = NIL;
                        st = ST_END;
                    end
                end
                default: ;
            endcase
            exp_status.push_back(st);
            exp_key.push_back(ko);
            exp_val.push_back(vo);
            exp_total.push_back(7'(held));
            exp_end.push_back(iter >= SLOTS);
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] ko, logic [31:0] vo,
                                   logic [6:0] tot, logic fin);
            logic [2:0]  e_st;
            logic [31:0] e_ko;
            logic [31:0] e_vo;
            logic [6:0]  e_tot;
            logic        e_fin;
            if (exp_status.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d", $time, st);
                errors++;
                return;
            end
            e_st = exp_status.pop_front();
            e_ko = exp_key.pop_front();
            e_vo = exp_val.pop_front();
            e_tot = exp_total.pop_front();
            e_fin = exp_end.pop_front();
            if (st !== e_st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e_st, st);
                errors++;
            end
            if (ko !== e_ko)
            begin
                $display("%0t: key_out expected %h actual %h", $time, e_ko, ko);
                errors++;
            end
            if (vo !== e_vo)
            begin
                $display("%0t: value_out expected %h actual %h", $time, e_vo, vo);
                errors++;
            end
            if (tot !== e_tot)
            begin
                $display("%0t: entry_total expected %0d actual %0d", $time, e_tot, tot);
                errors++;
            end
            if (fin !== e_fin)
            begin
                $display("%0t: at_end expected %0b actual %0b", $time, e_fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = CMD_LOOKUP;
    logic signed [31:0] key = '0;
    logic [31:0]        value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] key_out;
    logic [31:0]        value_out;
    logic [6:0]         entry_total;
    logic               at_end;

    map_scoreboard map_sb = new();
    int                 send_idle = 0;
    int                 recv_idle = 0;
    int                 hold_cycles = 0;
    logic [31:0]        key_pool [80];

    keyed_list_map #(.CAPACITY(SLOTS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .key_out(key_out), .value_out(value_out),
        .entry_total(entry_total), .at_end(at_end)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            map_sb.check_result(status, key_out, value_out, entry_total, at_end);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // offer one command beat and wait for it to be taken
    task automatic send_command(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        map_sb.note_command(cmd, k, v);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (map_sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0)
            return $urandom;
        return key_pool[$urandom_range(79)];
    endfunction

    task automatic random_commands(int count);
        int          roll;
        int          grow;
        logic [2:0]  cmd;
        for (int n = 0; n < count; n++)
        begin
            // first half of each run leans towards inserts so the list grows
            grow = (n < count / 2) ? 30 : 0;
            roll = $urandom_range(99);
            if (roll < 25 + grow)
                cmd = CMD_INSERT;
            else if (roll < 50 + grow / 2)
                cmd = CMD_LOOKUP;
            else if (roll < 72 + grow / 3)
                cmd = CMD_REMOVE;
            else if (roll < 78)
                cmd = CMD_IRESET;
            else if (roll < 97)
                cmd = CMD_ISTEP;
            else
                cmd = 3'($urandom_range(7, 5));
            send_command(cmd, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        int i;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (i = 4; i < 80; i++)
            key_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // free stack is swept in after reset
        repeat (2 * SLOTS + 8) @(posedge clk);

        // directed: empty map, extremes, update, iterator walk, unknown codes
        send_command(CMD_IRESET, 32'h0, 32'h0);
        send_command(CMD_ISTEP, 32'h0, 32'h0);
        send_command(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        send_command(CMD_REMOVE, 32'h7fff_ffff, 32'h0);
        send_command(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_command(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_command(CMD_INSERT, 32'h0000_0000, 32'h5555_aaaa);
        send_command(CMD_INSERT, 32'hffff_ffff, 32'haaaa_5555);
        send_command(CMD_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_command(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        send_command(CMD_LOOKUP, 32'hffff_ffff, 32'h0);
        send_command(CMD_IRESET, 32'h0, 32'h0);
        send_command(CMD_ISTEP, 32'h0, 32'h0);
        // remove the entry under the iterator
        send_command(CMD_REMOVE, 32'h0000_0000, 32'h0);
        send_command(CMD_ISTEP, 32'h0, 32'h0);
        send_command(CMD_ISTEP, 32'h0, 32'h0);
        send_command(CMD_ISTEP, 32'h0, 32'h0);
        send_command(3'd5, 32'hffff_ffff, 32'hffff_ffff);
        send_command(3'd6, 32'h0, 32'h0);
        send_command(3'd7, 32'h1, 32'h1);
        send_command(CMD_REMOVE, 32'hffff_ffff, 32'h0);
        send_command(CMD_LOOKUP, 32'hffff_ffff, 32'h0);

        // fill the store, then refuse a new key and update an old one
        while (map_sb.held < SLOTS)
            send_command(CMD_INSERT, $urandom, $urandom);
        send_command(CMD_INSERT, 32'h0000_0000, $urandom);
        send_command(CMD_INSERT, $urandom, $urandom);
        send_command(CMD_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_command(CMD_IRESET, 32'h0, 32'h0);
        drain_results();

        // long receiver hold-off while commands keep coming
        hold_cycles = 400;
        send_idle = 32;
        recv_idle = 83;
        random_commands(170);
        drain_results();

        send_idle = 83;
        recv_idle = 32;
        random_commands(170);
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        random_commands(170);
        drain_results();

        repeat (2 * SLOTS + 20) @(posedge clk);
        if (map_sb.errors == 0 && map_sb.pending() == 0)
            $display("keyed_list_map: match");
        else
            $display("keyed_list_map: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("keyed_list_map: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/klm_pkg.sv
design/klm_ram.sv
design/klm_datapath.sv
design/klm_ctrl.sv
design/keyed_list_map.sv
bench/keyed_list_map_tb.sv
